### hw/rtl/stbs_pkg.sv
// Shared constants and types of the sorted-table binary search block.
`timescale 1ns / 1ps
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = IDX_W + 1;
    localparam int DATA_W      = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    // Word index of the entry_count register on the configuration port.
    localparam logic REG_ENTRY_COUNT = 1'b0;

    typedef enum logic {
        ACT_LOAD   = 1'b0,
        ACT_SEARCH = 1'b1
    } t_action;

endpackage

`default_nettype wire

### hw/rtl/stbs_if.sv
// Request and response channel interfaces of the sorted-table binary search.
`timescale 1ns / 1ps
`default_nettype none

interface stbs_req_if
    import stbs_pkg::*;
();
    logic                      valid;
    logic                      ready;
    t_action                   action;
    logic [IDX_W-1:0]          entry_index;
    logic signed [DATA_W-1:0]  entry_value;
    logic signed [DATA_W-1:0]  search_key;

    modport source (output valid, action, entry_index, entry_value, search_key,
                    input ready);
    modport sink   (input valid, action, entry_index, entry_value, search_key,
                    output ready);
endinterface

interface stbs_rsp_if
    import stbs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             found;
    logic [IDX_W-1:0] found_index;

    modport source (output valid, found, found_index, input ready);
    modport sink   (input valid, found, found_index, output ready);
endinterface

`default_nettype wire

### hw/rtl/sorted_table_binary_search.sv
// Top level of the sorted-table binary search block.
`timescale 1ns / 1ps
`default_nettype none

// The block keeps a 1024 x 32-bit table of signed entries in one synchronous
// RAM; the first entry_count entries are taken as sorted ascending. A load
// request (action 0) writes one entry in the cycle it is accepted and gives
// no response. A search request (action 1) runs a binary search over
// positions 0 .. entry_count-1 and gives one response: found and the index of
// the first probed match (index 0 when not found). entry_count above 1024
// acts as 1024. Each probe reads the RAM in S_READ and compares in S_CMP,
// because the RAM has a single read port with registered read data; a search
// goes from accept through these states per probe, then S_EMIT into the
// response register; a full table needs at most 11 probes, an empty one
// none. One request is worked on at a time: a load is done on accept, and
// the next request is taken once a search has put its response in the output
// register, even while that response still waits to be taken. Table entries
// have no reset; search only entries that have been loaded. entry_count sits
// at byte address 0 of the APB-style port and resets to 0; write it only
// while no search is running.
module sorted_table_binary_search
    import stbs_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    stbs_req_if.sink                   i_req,
    stbs_rsp_if.source                 o_rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_EMIT
    } t_state;

    // Control state
    t_state              r_state,     n_state;
    logic                r_out_valid, n_out_valid;
    logic [CNT_W-1:0]    r_entry_count;

    // Search datapath (no reset needed)
    logic [CNT_W-1:0]          r_left,    n_left;
    logic [CNT_W-1:0]          r_hi,      n_hi;       // exclusive upper bound
    logic [IDX_W-1:0]          r_mid,     n_mid;
    logic signed [DATA_W-1:0]  r_key,     n_key;
    logic                      r_hit,     n_hit;
    logic [IDX_W-1:0]          r_hit_idx, n_hit_idx;
    logic                      r_out_found, n_out_found;
    logic [IDX_W-1:0]          r_out_index, n_out_index;

    logic                      req_accept;
    logic                      out_free;
    logic [CNT_W-1:0]          count_sat;
    logic [CNT_W:0]            mid_sum;
    logic [IDX_W-1:0]          mid;
    logic [CNT_W-1:0]          mid_next;
    logic signed [DATA_W-1:0]  probe;
    logic [DATA_W-1:0]         ram_rdata;
    logic                      ram_we;
    logic                      ram_re;
    logic                      cfg_write;

    // ---------------------------------------------------------------
    // Configuration port: single register, always ready
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[APB_ADDR_W-1] == REG_ENTRY_COUNT);

    always_comb begin
        prdata = '0;
        if (paddr[APB_ADDR_W-1] == REG_ENTRY_COUNT) begin
            prdata = APB_DATA_W'(r_entry_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (cfg_write) begin
            r_entry_count <= pwdata[CNT_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Handshakes
    // ---------------------------------------------------------------
    assign i_req.ready = (r_state == S_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;
    // The response register can take a new result when empty or being drained.
    assign out_free    = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out_found;
    assign o_rsp.found_index = r_out_index;

    // ---------------------------------------------------------------
    // Table RAM
    // ---------------------------------------------------------------
    assign ram_we = req_accept && (i_req.action == ACT_LOAD);
    assign ram_re = (r_state == S_READ);

    stbs_table_ram u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_req.entry_index),
        .i_wdata (i_req.entry_value),
        .i_re    (ram_re),
        .i_raddr (mid),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // Search arithmetic
    // ---------------------------------------------------------------
    // Saturate the entry count at the table depth.
    assign count_sat = (r_entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : r_entry_count;
    // Midpoint of [left, hi-1]; left < hi holds whenever this is used.
    assign mid_sum  = {1'b0, r_left} + {1'b0, r_hi} - (CNT_W+1)'(1);
    assign mid      = mid_sum[IDX_W:1];
    assign mid_next = CNT_W'(r_mid) + CNT_W'(1);
    assign probe    = $signed(ram_rdata);

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_left      = r_left;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_hit       = r_hit;
        n_hit_idx   = r_hit_idx;
        n_out_found = r_out_found;
        n_out_index = r_out_index;

        // Drop the response once taken; a new one may replace it below.
        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (req_accept && (i_req.action == ACT_SEARCH)) begin
                    n_key     = i_req.search_key;
                    n_left    = '0;
                    n_hi      = count_sat;
                    n_hit     = 1'b0;
                    n_hit_idx = '0;
                    n_state   = (count_sat == '0) ? S_EMIT : S_READ;
                end
            end
            S_READ: begin
                // Address goes to the RAM this cycle; data is back next cycle.
                n_mid   = mid;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (r_key == probe) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_mid;
                    n_state   = S_EMIT;
                end else if (r_key > probe) begin
                    n_left  = mid_next;
                    n_state = (mid_next < r_hi) ? S_READ : S_EMIT;
                end else begin
                    n_hi    = CNT_W'(r_mid);
                    n_state = (r_left < CNT_W'(r_mid)) ? S_READ : S_EMIT;
                end
            end
            S_EMIT: begin
                // Hold the result until the response register is free.
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_found = r_hit;
                    n_out_index = r_hit_idx;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left      <= n_left;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_key       <= n_key;
        r_hit       <= n_hit;
        r_hit_idx   <= n_hit_idx;
        r_out_found <= n_out_found;
        r_out_index <= n_out_index;
    end

endmodule

`default_nettype wire

### hw/rtl/stbs_table_ram.sv
// Table memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module stbs_table_ram
    import stbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [IDX_W-1:0]  i_waddr,
    input  wire logic [DATA_W-1:0] i_wdata,
    input  wire logic              i_re,
    input  wire logic [IDX_W-1:0]  i_raddr,
    output logic      [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [TABLE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/stbs_checker.sv
// Port-level assertions of the sorted-table binary search, bound to the top.
`timescale 1ns / 1ps
`default_nettype none

module stbs_checker
    import stbs_pkg::*;
(
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_in_valid,
    input wire logic             i_in_ready,
    input wire logic             i_in_action,
    input wire logic             i_out_valid,
    input wire logic             i_out_ready,
    input wire logic             i_out_found,
    input wire logic [IDX_W-1:0] i_out_index
);

    // Stalled response holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_found) && $stable(i_out_index))
        else $error("response changed while stalled");

    // A miss reports index zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_found |-> i_out_index == '0)
        else $error("miss with nonzero index");

    // A search request blocks further requests while it runs.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_SEARCH) |=> !i_in_ready)
        else $error("request taken during a search");

    // A load request keeps the request port ready in the cycle after it.
    a_load_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_LOAD) |=> i_in_ready)
        else $error("load did not complete in one cycle");

    // A new response only follows a search that held off requests.
    a_rsp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("response without a running search");

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_req.valid),
    .i_in_ready  (i_req.ready),
    .i_in_action (i_req.action),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_out_found (o_rsp.found),
    .i_out_index (o_rsp.found_index)
);

`default_nettype wire

### dv/stbs_search_checker.sv
// Checker for the sorted-table binary search: predicts search responses and compares them.
`timescale 1ns / 1ps

module stbs_search_checker
    import stbs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    stbs_req_if                   i_req,
    stbs_rsp_if                   i_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    o_fail_count,
    output int                    o_pending
);

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] index;
    } t_lookup;

    logic signed [DATA_W-1:0] entry_store [TABLE_DEPTH];
    logic [CNT_W-1:0]         entry_count;
    t_lookup                  lookup_q [$];
    int                       mismatches = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // Walk the probe sequence over the entries in use; stop at the first equal probe.
    function automatic t_lookup lookup_key(input logic signed [DATA_W-1:0] key);
        t_lookup res;
        int      lo;
        int      hi;
        int      mid;
        int      span;
        res  = '0;
        span = (entry_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(entry_count);
        lo   = 0;
        hi   = span - 1;
        while (lo <= hi && !res.found) begin
            mid = lo + (hi - lo) / 2;
            if (key == entry_store[mid]) begin
                res.found = 1'b1;
                res.index = mid[IDX_W-1:0];
            end else if (key > entry_store[mid]) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_lookup got;
        t_lookup want;
        if (!i_rst_n) begin
            lookup_q.delete();
            entry_count = '0;
        end else begin
            if (i_rsp.valid && i_rsp.ready) begin
                got.found = i_rsp.found;
                got.index = i_rsp.found_index;
                if (lookup_q.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: response with no search pending: found=%0b index=%0d",
                                 $realtime, got.found, got.index);
                    mismatches++;
                end else begin
                    want = lookup_q.pop_front();
                    if (want.found !== got.found || want.index !== got.index) begin
                        if (mismatches < 10)
                            $display("%0t: search mismatch: expected found=%0b index=%0d, got found=%0b index=%0d",
                                     $realtime, want.found, want.index, got.found, got.index);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                if (i_req.action == ACT_LOAD)
                    entry_store[i_req.entry_index] = i_req.entry_value;
                else
                    lookup_q.push_back(lookup_key(i_req.search_key));
            end
            if (psel && penable && pwrite && pready
                && paddr[APB_ADDR_W-1:2] == REG_ENTRY_COUNT)
                entry_count = pwdata[CNT_W-1:0];
        end
        o_pending    <= lookup_q.size();
        o_fail_count <= mismatches;
    end

endmodule

### dv/sorted_table_binary_search_test.sv
// Top of the sorted-table binary search testbench: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module sorted_table_binary_search_test;
    import stbs_pkg::*;

    localparam int ITEM_TARGET   = 1350;
    localparam int CALM_ITEMS    = 150;     // final stretch without idling
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 400000;
    localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7fff_ffff;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int requests_sent = 0;

    // Idling switches, changed per phase; both go off for the final stretch.
    bit tx_idle = 1'b0;
    bit rx_idle = 1'b0;

    // Stimulus-side memory of what has been loaded, used only to choose keys
    // and to keep searches away from entries never written since reset.
    logic signed [DATA_W-1:0] loaded_value [TABLE_DEPTH];
    bit                       written [TABLE_DEPTH];
    int                       written_total = 0;

    stbs_req_if req_if ();
    stbs_rsp_if rsp_if ();

    sorted_table_binary_search DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    stbs_search_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #1 i_clk = ~i_clk;

    // Watchdog: end a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Response side: alternate ready stretches with random stall bursts.
    // One assignment per loop pass, and every pass waits on the clock.
    initial begin
        forever begin
            if (rx_idle && $urandom_range(0, 2) == 0) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
            end else begin
                rsp_if.ready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
        end
    end

    // Present one request and hold it until accepted. Valid stays high on
    // return so that a back-to-back request needs no second assignment.
    task automatic send_request(input t_action act, input logic [IDX_W-1:0] idx,
                                input logic signed [DATA_W-1:0] value,
                                input logic signed [DATA_W-1:0] key);
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.action      <= act;
        req_if.entry_index <= idx;
        req_if.entry_value <= value;
        req_if.search_key  <= key;
        do @(posedge i_clk); while (!req_if.ready);
        requests_sent++;
        if (act == ACT_LOAD) begin
            loaded_value[idx] = value;
            if (!written[idx]) begin
                written[idx] = 1'b1;
                written_total++;
            end
        end
    endtask

    task automatic load_entry(input int idx, input logic signed [DATA_W-1:0] value);
        send_request(ACT_LOAD, idx[IDX_W-1:0], value, $urandom);
    endtask

    task automatic search_for(input logic signed [DATA_W-1:0] key);
        send_request(ACT_SEARCH, IDX_W'($urandom), $urandom, key);
    endtask

    // Drop valid, wait for every outstanding response, then let the block go idle.
    // Wait on the clock first so the pending count covers the last accepted request.
    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write entry_count: setup cycle, then access cycle until pready.
    // Fill the unused upper data bits with noise.
    task automatic write_entry_count(input int count);
        logic [APB_DATA_W-1:0] word;
        word             = $urandom;
        word[CNT_W-1:0]  = count[CNT_W-1:0];
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_ENTRY_COUNT, 2'b00};
        pwdata  <= word;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    // Load positions 0 .. n-1 with a non-decreasing run; step 0 gives duplicates.
    task automatic load_sorted(input int n, input int unsigned step_cap);
        longint v;
        int     i;
        case ($urandom_range(0, 7))
            0: v = MIN_VALUE;
            1: v = longint'(MAX_VALUE) - longint'(n) * step_cap / 2;
            default: v = int'($urandom);
        endcase
        if (v < MIN_VALUE)
            v = MIN_VALUE;
        for (i = 0; i < n; i++) begin
            load_entry(i, v[DATA_W-1:0]);
            v = v + $urandom_range(0, step_cap);
            if (v > MAX_VALUE)
                v = MAX_VALUE;
        end
    endtask

    // Favor keys that sit in the table, then near misses, then anything.
    function automatic logic signed [DATA_W-1:0] pick_key(input int count);
        int span;
        logic signed [DATA_W-1:0] hit;
        span = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
        hit  = (span > 0) ? loaded_value[$urandom_range(0, span - 1)] : int'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return hit;
            5:       return hit + 1;
            6:       return hit - 1;
            7:       return int'($urandom);
            8:       return MIN_VALUE;
            default: return MAX_VALUE;
        endcase
    endfunction

    task automatic search_batch(input int count, input int searches, input bit noisy);
        int k;
        for (k = 0; k < searches; k++) begin
            // Drop in a stray load now and then; it may break the ordering.
            if (noisy && $urandom_range(0, 9) == 0)
                load_entry($urandom_range(0, TABLE_DEPTH - 1), int'($urandom));
            search_for(pick_key(count));
        end
    endtask

    initial begin : stimulus
        int phase;
        int count;
        int unsigned step_cap;

        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.action      <= ACT_LOAD;
        req_if.entry_index <= '0;
        req_if.entry_value <= '0;
        req_if.search_key  <= '0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table right out of reset.
        search_for(32'sd0);

        // Hold the extremes at both ends of a three-entry table, and touch the last slot.
        load_entry(0, MIN_VALUE);
        load_entry(1, 32'sd0);
        load_entry(2, MAX_VALUE);
        load_entry(TABLE_DEPTH - 1, -32'sd1);
        settle();
        write_entry_count(3);
        search_for(MIN_VALUE);
        search_for(MAX_VALUE);
        search_for(32'sd0);
        search_for(32'sd1);
        search_for(-32'sd1);
        search_for(MAX_VALUE - 1);

        // Overwrite entry 1 with MAX_VALUE: the table stays sorted but no longer holds 0.
        load_entry(1, MAX_VALUE);
        search_for(32'sd0);
        search_for(MAX_VALUE);
        settle();

        // Single entry, then back to an empty table.
        write_entry_count(1);
        search_for(MIN_VALUE);
        search_for(MAX_VALUE);
        settle();
        write_entry_count(0);
        search_for(MIN_VALUE);
        settle();

        // Random phases: load a sorted table, set the count, search it.
        phase = 0;
        while (requests_sent < ITEM_TARGET) begin
            if (requests_sent > ITEM_TARGET - CALM_ITEMS) begin
                tx_idle = 1'b0;
                rx_idle = 1'b0;
            end else begin
                tx_idle = ($urandom_range(0, 3) != 0);
                rx_idle = ($urandom_range(0, 3) != 0);
            end

            if (phase == 0) begin
                // Fill the whole table once; this also opens the saturated counts.
                load_sorted(TABLE_DEPTH, 1 << 21);
                settle();
                write_entry_count(TABLE_DEPTH);
                search_for(loaded_value[0]);
                search_for(loaded_value[TABLE_DEPTH - 1]);
                search_batch(TABLE_DEPTH, 14, 1'b0);
                settle();
                write_entry_count((1 << CNT_W) - 1);
                search_batch(TABLE_DEPTH, 14, 1'b0);
                settle();
                write_entry_count($urandom_range(TABLE_DEPTH + 1, (1 << CNT_W) - 2));
                search_batch(TABLE_DEPTH, 10, 1'b1);
            end else begin
                if (written_total == TABLE_DEPTH && $urandom_range(0, 3) == 0) begin
                    // Every entry is written: any count is legal, ordered or not.
                    count = $urandom_range(0, (1 << CNT_W) - 1);
                end else begin
                    case ($urandom_range(0, 7))
                        0:       count = $urandom_range(0, 2);
                        1:       count = $urandom_range(25, 90);
                        default: count = $urandom_range(3, 24);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       step_cap = 1;
                        1:       step_cap = 16;
                        2:       step_cap = 1 << 16;
                        default: step_cap = 1 << 24;
                    endcase
                    load_sorted(count, step_cap);
                    settle();
                end
                write_entry_count(count);
                search_batch(count, $urandom_range(15, 40), 1'b1);
            end
            settle();
            phase++;
        end

        // Drain: settle waits for every response, then the idle margin.
        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
